// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, codes and character constants of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int LINE_W = 16;
   localparam int COL_W  = 12;
   localparam int REC_MAX = 3;
   localparam int CNT_W   = 2;

   localparam logic [LINE_W-1:0] FIRST_LINE_RESET   = 16'd1;
   localparam logic [COL_W-1:0]  FIRST_COLUMN_RESET = 12'd0;

   // Register indexes (taken from byte address bit 2).
   localparam logic CSR_FIRST_LINE   = 1'b0;
   localparam logic CSR_FIRST_COLUMN = 1'b1;

   // Record kinds.
   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Token types.
   localparam logic [3:0] TOK_IDENT  = 4'd0;
   localparam logic [3:0] TOK_NUMBER = 4'd1;
   localparam logic [3:0] TOK_STRING = 4'd2;
   localparam logic [3:0] TOK_IF     = 4'd3;
   localparam logic [3:0] TOK_FUNC   = 4'd4;
   localparam logic [3:0] TOK_RETURN = 4'd5;
   localparam logic [3:0] TOK_WHILE  = 4'd6;
   localparam logic [3:0] TOK_LPAREN = 4'd7;
   localparam logic [3:0] TOK_RPAREN = 4'd8;
   localparam logic [3:0] TOK_LBRACE = 4'd9;
   localparam logic [3:0] TOK_RBRACE = 4'd10;
   localparam logic [3:0] TOK_COMMA  = 4'd11;
   localparam logic [3:0] TOK_SEMI   = 4'd12;
   localparam logic [3:0] TOK_ASSIGN = 4'd13;
   localparam logic [3:0] TOK_EOF    = 4'd14;

   // Error codes.
   localparam logic ERR_UNEXPECTED   = 1'b0;
   localparam logic ERR_UNTERMINATED = 1'b1;

   // Characters.
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_N          = 8'h6E;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_ASSIGN     = 8'h3D;

   // Keyword spellings, first character in the top byte.
   localparam logic [15:0] KW_IF     = "if";
   localparam logic [31:0] KW_FUNC   = "func";
   localparam logic [47:0] KW_RETURN = "return";
   localparam logic [39:0] KW_WHILE  = "while";

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_STRING = 3'd3,
      MODE_ESCAPE = 3'd4
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type     mode;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
      logic [LINE_W-1:0] tok_line;
      logic [COL_W-1:0]  tok_col;
   } scan_state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        token_type;
      logic [7:0]        value;
      logic [LINE_W-1:0] start_line;
      logic [COL_W-1:0]  start_col;
      logic [LINE_W-1:0] end_line;
      logic [COL_W-1:0]  end_col;
      logic              err;
   } record_type;

endpackage

// ===== design/stt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel carrying one source byte per word.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

// ===== design/stt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result channel
// Valid/ready channel carrying one value, token or error record per word.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                record_kind;
   logic [3:0]                token_type;
   logic [7:0]                value_byte;
   logic [stt_pkg::LINE_W-1:0] start_line;
   logic [stt_pkg::COL_W-1:0]  start_column;
   logic [stt_pkg::LINE_W-1:0] end_line;
   logic [stt_pkg::COL_W-1:0]  end_column;
   logic                      error_code;
   logic                      last;

   modport source (output valid, output record_kind, output token_type, output value_byte,
                   output start_line, output start_column, output end_line,
                   output end_column, output error_code, output last, input ready);
   modport sink (input valid, input record_kind, input token_type, input value_byte,
                 input start_line, input start_column, input end_line,
                 input end_column, input error_code, input last, output ready);
endinterface

// ===== design/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexical scanner: one source byte in, value, token and error
// records out, with line and column tracking.
// ----------------------------------------------------------------------------
// The records of an accepted byte are offered in the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one record and the
// result channel is ready; a byte yielding more records (up to 3) holds the input
// until the single record port has drained the three-entry record buffer.
// Reset: synchronous, active high; clears the scan, restores first_line to 1 and
// first_column to 0, and empties the record buffer.
module source_text_tokenizer #(
   parameter int MAX_KEYWORD_LEN = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   stt_req_if.sink     req_ch,
   stt_rsp_if.source   rsp_ch
);

   localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 2);

   // Configuration registers.
   logic [stt_pkg::LINE_W-1:0] first_line_ff, first_line_in;
   logic [stt_pkg::COL_W-1:0]  first_col_ff, first_col_in;

   // Scan state: mode, running location, token start and identifier buffer.
   stt_pkg::scan_state_type scan_ff, scan_in, scan_nxt;
   logic [LEN_W-1:0] wlen_ff, wlen_in, wlen_nxt;
   logic [7:0]       wbuf_ff [MAX_KEYWORD_LEN];
   logic [7:0]       wbuf_nxt [MAX_KEYWORD_LEN];

   // Record buffer: the records of the last accepted byte, oldest in entry zero.
   stt_pkg::record_type       rec_ff [stt_pkg::REC_MAX];
   stt_pkg::record_type       rec_in [stt_pkg::REC_MAX];
   stt_pkg::record_type       rec_nxt [stt_pkg::REC_MAX];
   logic [stt_pkg::CNT_W-1:0] cnt_ff, cnt_in, rec_count;

   logic cfg_wr;
   logic accept;
   logic pop;

   // The scan step sees the byte straight from the channel and the stored state.
   stt_scan #(
      .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
   ) u_scan (
      .char_byte    (req_ch.char_byte),
      .cur          (scan_ff),
      .word_len     (wlen_ff),
      .word_buf     (wbuf_ff),
      .first_line   (first_line_ff),
      .first_column (first_col_ff),
      .nxt          (scan_nxt),
      .nxt_len      (wlen_nxt),
      .nxt_buf      (wbuf_nxt),
      .recs         (rec_nxt),
      .rec_count    (rec_count)
   );

   // A new byte is taken when the buffer is empty, or when its last record leaves
   // in this same cycle, so single-record bytes stream every cycle while output is ready.
   assign req_ch.ready = (cnt_ff == '0) ||
                         (cnt_ff == stt_pkg::CNT_W'(1) && rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;

   // The APB port never waits; a write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         stt_pkg::CSR_FIRST_LINE:   csr_prdata[stt_pkg::LINE_W-1:0] = first_line_ff;
         stt_pkg::CSR_FIRST_COLUMN: csr_prdata[stt_pkg::COL_W-1:0]  = first_col_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // Next configuration and scan state. A register write also loads the running
   // location; the user must configure only while idle; the block does not check.
   always_comb begin
      first_line_in = first_line_ff;
      first_col_in  = first_col_ff;
      scan_in       = accept ? scan_nxt : scan_ff;
      wlen_in       = accept ? wlen_nxt : wlen_ff;
      if (cfg_wr) begin
         case (csr_paddr[2])
            stt_pkg::CSR_FIRST_LINE: begin
               first_line_in = csr_pwdata[stt_pkg::LINE_W-1:0];
               scan_in.line  = csr_pwdata[stt_pkg::LINE_W-1:0];
            end
            stt_pkg::CSR_FIRST_COLUMN: begin
               first_col_in = csr_pwdata[stt_pkg::COL_W-1:0];
               scan_in.col  = csr_pwdata[stt_pkg::COL_W-1:0];
            end
            default: begin
               first_line_in = first_line_ff;
            end
         endcase
      end
   end

   // Record buffer: load on accept, otherwise shift out one record per pop.
   always_comb begin
      rec_in = rec_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         rec_in = rec_nxt;
         cnt_in = rec_count;
      end else if (pop) begin
         for (int i = 0; i < stt_pkg::REC_MAX - 1; i++) begin
            rec_in[i] = rec_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff    <= stt_pkg::FIRST_LINE_RESET;
         first_col_ff     <= stt_pkg::FIRST_COLUMN_RESET;
         scan_ff.mode     <= stt_pkg::MODE_IDLE;
         scan_ff.line     <= stt_pkg::FIRST_LINE_RESET;
         scan_ff.col      <= stt_pkg::FIRST_COLUMN_RESET;
         scan_ff.tok_line <= '0;
         scan_ff.tok_col  <= '0;
         wlen_ff          <= '0;
         cnt_ff           <= '0;
      end else begin
         first_line_ff <= first_line_in;
         first_col_ff  <= first_col_in;
         scan_ff       <= scan_in;
         wlen_ff       <= wlen_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload storage carries no reset; entries are read only below the counts.
   always_ff @(posedge clock) begin
      if (accept) begin
         wbuf_ff <= wbuf_nxt;
      end
      rec_ff <= rec_in;
   end

   // The head of the buffer drives the result channel.
   assign rsp_ch.valid        = (cnt_ff != '0);
   assign rsp_ch.record_kind  = rec_ff[0].kind;
   assign rsp_ch.token_type   = rec_ff[0].token_type;
   assign rsp_ch.value_byte   = rec_ff[0].value;
   assign rsp_ch.start_line   = rec_ff[0].start_line;
   assign rsp_ch.start_column = rec_ff[0].start_col;
   assign rsp_ch.end_line     = rec_ff[0].end_line;
   assign rsp_ch.end_column   = rec_ff[0].end_col;
   assign rsp_ch.error_code   = rec_ff[0].err;
   assign rsp_ch.last         = (cnt_ff == stt_pkg::CNT_W'(1));

endmodule

// ===== design/stt_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scan step
// Classifies one byte against the scan state and forms the next state and
// up to three result records.
// ----------------------------------------------------------------------------
module stt_scan #(
   parameter int MAX_KEYWORD_LEN = 6
) (
   input  logic [7:0]                    char_byte,
   input  stt_pkg::scan_state_type       cur,
   input  logic [$clog2(MAX_KEYWORD_LEN+2)-1:0] word_len,
   input  logic [7:0]                    word_buf [MAX_KEYWORD_LEN],
   input  logic [stt_pkg::LINE_W-1:0]    first_line,
   input  logic [stt_pkg::COL_W-1:0]     first_column,
   output stt_pkg::scan_state_type       nxt,
   output logic [$clog2(MAX_KEYWORD_LEN+2)-1:0] nxt_len,
   output logic [7:0]                    nxt_buf [MAX_KEYWORD_LEN],
   output stt_pkg::record_type           recs [stt_pkg::REC_MAX],
   output logic [stt_pkg::CNT_W-1:0]     rec_count
);

   localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 2);
   localparam int BUF_W = $clog2(MAX_KEYWORD_LEN);

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == stt_pkg::CH_SPACE) || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
   endfunction

   function automatic logic [stt_pkg::LINE_W-1:0] step_line(
      input logic [7:0] c, input logic [stt_pkg::LINE_W-1:0] l);
      step_line = (c == stt_pkg::CH_NEWLINE && l != '1) ? l + 1'b1 : l;
   endfunction

   function automatic logic [stt_pkg::COL_W-1:0] step_col(
      input logic [7:0] c, input logic [stt_pkg::COL_W-1:0] k);
      if (c == stt_pkg::CH_NEWLINE) begin
         step_col = '0;
      end else begin
         step_col = (k != '1) ? k + 1'b1 : k;
      end
   endfunction

   function automatic stt_pkg::record_type mk_rec(
      input logic [1:0] kind, input logic [3:0] ttype, input logic [7:0] val,
      input logic [stt_pkg::LINE_W-1:0] sl, input logic [stt_pkg::COL_W-1:0] sc,
      input logic [stt_pkg::LINE_W-1:0] el, input logic [stt_pkg::COL_W-1:0] ec,
      input logic err);
      mk_rec.kind       = kind;
      mk_rec.token_type = ttype;
      mk_rec.value      = val;
      mk_rec.start_line = sl;
      mk_rec.start_col  = sc;
      mk_rec.end_line   = el;
      mk_rec.end_col    = ec;
      mk_rec.err        = err;
   endfunction

   logic [3:0] kw_type;
   logic       punct_hit;
   logic [3:0] punct_type;

   // Keyword match over the first six buffered characters.
   always_comb begin
      kw_type = stt_pkg::TOK_IDENT;
      if (word_len == LEN_W'(2) && {word_buf[0], word_buf[1]} == stt_pkg::KW_IF) begin
         kw_type = stt_pkg::TOK_IF;
      end else if (word_len == LEN_W'(4) &&
                   {word_buf[0], word_buf[1], word_buf[2], word_buf[3]} == stt_pkg::KW_FUNC) begin
         kw_type = stt_pkg::TOK_FUNC;
      end else if (word_len == LEN_W'(6) &&
                   {word_buf[0], word_buf[1], word_buf[2], word_buf[3], word_buf[4],
                    word_buf[5]} == stt_pkg::KW_RETURN) begin
         kw_type = stt_pkg::TOK_RETURN;
      end else if (word_len == LEN_W'(5) &&
                   {word_buf[0], word_buf[1], word_buf[2], word_buf[3],
                    word_buf[4]} == stt_pkg::KW_WHILE) begin
         kw_type = stt_pkg::TOK_WHILE;
      end
   end

   always_comb begin
      punct_hit  = 1'b1;
      punct_type = stt_pkg::TOK_LPAREN;
      case (char_byte)
         stt_pkg::CH_LPAREN: punct_type = stt_pkg::TOK_LPAREN;
         stt_pkg::CH_RPAREN: punct_type = stt_pkg::TOK_RPAREN;
         stt_pkg::CH_LBRACE: punct_type = stt_pkg::TOK_LBRACE;
         stt_pkg::CH_RBRACE: punct_type = stt_pkg::TOK_RBRACE;
         stt_pkg::CH_COMMA:  punct_type = stt_pkg::TOK_COMMA;
         stt_pkg::CH_SEMI:   punct_type = stt_pkg::TOK_SEMI;
         stt_pkg::CH_ASSIGN: punct_type = stt_pkg::TOK_ASSIGN;
         default:            punct_hit  = 1'b0;
      endcase
   end

   always_comb begin
      logic [stt_pkg::CNT_W-1:0] n;
      logic                      between;
      logic                      eoi;
      logic                      eoi_str;
      logic [7:0]                c;
      c       = char_byte;
      n       = '0;
      between = 1'b0;
      eoi     = 1'b0;
      eoi_str = 1'b0;
      nxt     = cur;
      nxt_len = word_len;
      nxt_buf = word_buf;
      for (int i = 0; i < stt_pkg::REC_MAX; i++) begin
         recs[i] = '0;
      end

      case (cur.mode)
         stt_pkg::MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == stt_pkg::CH_UNDERSCORE) begin
               if (word_len < LEN_W'(MAX_KEYWORD_LEN)) begin
                  nxt_buf[word_len[BUF_W-1:0]] = c;
               end
               if (word_len <= LEN_W'(MAX_KEYWORD_LEN)) begin
                  nxt_len = word_len + 1'b1;
               end
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_IDENT, c,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.line = step_line(c, cur.line);
               nxt.col  = step_col(c, cur.col);
            end else begin
               recs[n] = mk_rec(stt_pkg::KIND_TOKEN, kw_type, '0,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.mode = stt_pkg::MODE_IDLE;
               between  = 1'b1;
            end
         end
         stt_pkg::MODE_NUMBER: begin
            if (is_digit(c)) begin
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_NUMBER, c,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.line = step_line(c, cur.line);
               nxt.col  = step_col(c, cur.col);
            end else begin
               recs[n] = mk_rec(stt_pkg::KIND_TOKEN, stt_pkg::TOK_NUMBER, '0,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.mode = stt_pkg::MODE_IDLE;
               between  = 1'b1;
            end
         end
         stt_pkg::MODE_STRING: begin
            if (c == stt_pkg::CH_NUL) begin
               eoi     = 1'b1;
               eoi_str = 1'b1;
            end else if (c == stt_pkg::CH_QUOTE) begin
               recs[n] = mk_rec(stt_pkg::KIND_TOKEN, stt_pkg::TOK_STRING, '0,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.mode = stt_pkg::MODE_IDLE;
               nxt.line = step_line(c, cur.line);
               nxt.col  = step_col(c, cur.col);
            end else begin
               if (c == stt_pkg::CH_BACKSLASH) begin
                  nxt.mode = stt_pkg::MODE_ESCAPE;
               end else begin
                  recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_STRING, c,
                                   cur.tok_line, cur.tok_col, '0, '0, 1'b0);
                  n = n + 1'b1;
               end
               nxt.line = step_line(c, cur.line);
               nxt.col  = step_col(c, cur.col);
            end
         end
         stt_pkg::MODE_ESCAPE: begin
            nxt.line = step_line(c, cur.line);
            nxt.col  = step_col(c, cur.col);
            if (c == stt_pkg::CH_NUL) begin
               eoi     = 1'b1;
               eoi_str = 1'b1;
            end else begin
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_STRING,
                                (c == stt_pkg::CH_N) ? stt_pkg::CH_NEWLINE : c,
                                cur.tok_line, cur.tok_col, '0, '0, 1'b0);
               n = n + 1'b1;
               nxt.mode = stt_pkg::MODE_STRING;
            end
         end
         default: begin
            nxt.mode = stt_pkg::MODE_IDLE;
            between  = 1'b1;
         end
      endcase

      // Handling of a byte that arrives between tokens.
      if (between) begin
         if (c == stt_pkg::CH_NUL) begin
            eoi = 1'b1;
         end else if (is_space(c)) begin
            nxt.line = step_line(c, cur.line);
            nxt.col  = step_col(c, cur.col);
         end else if (is_alpha(c) || is_digit(c) || c == stt_pkg::CH_QUOTE || punct_hit) begin
            nxt.tok_line = cur.line;
            nxt.tok_col  = cur.col;
            if (is_alpha(c)) begin
               nxt_buf[0] = c;
               nxt_len    = LEN_W'(1);
               nxt.mode   = stt_pkg::MODE_IDENT;
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_IDENT, c,
                                cur.line, cur.col, '0, '0, 1'b0);
               n = n + 1'b1;
            end else if (is_digit(c)) begin
               nxt.mode = stt_pkg::MODE_NUMBER;
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, stt_pkg::TOK_NUMBER, c,
                                cur.line, cur.col, '0, '0, 1'b0);
               n = n + 1'b1;
            end else if (c == stt_pkg::CH_QUOTE) begin
               nxt.mode = stt_pkg::MODE_STRING;
            end else begin
               recs[n] = mk_rec(stt_pkg::KIND_VALUE, punct_type, c,
                                cur.line, cur.col, '0, '0, 1'b0);
               n = n + 1'b1;
               recs[n] = mk_rec(stt_pkg::KIND_TOKEN, punct_type, '0,
                                cur.line, cur.col, '0, '0, 1'b0);
               n = n + 1'b1;
            end
            nxt.line = step_line(c, cur.line);
            nxt.col  = step_col(c, cur.col);
         end else begin
            recs[n] = mk_rec(stt_pkg::KIND_ERROR, stt_pkg::TOK_IDENT, '0,
                             cur.line, cur.col, cur.line, cur.col, stt_pkg::ERR_UNEXPECTED);
            n = n + 1'b1;
            nxt.line = step_line(c, cur.line);
            nxt.col  = step_col(c, cur.col);
         end
      end

      // End of input closes an open string, emits end of file and clears the scan.
      if (eoi) begin
         if (eoi_str) begin
            recs[n] = mk_rec(stt_pkg::KIND_ERROR, stt_pkg::TOK_IDENT, '0,
                             cur.tok_line, cur.tok_col, nxt.line, nxt.col,
                             stt_pkg::ERR_UNTERMINATED);
            n = n + 1'b1;
            recs[n] = mk_rec(stt_pkg::KIND_TOKEN, stt_pkg::TOK_STRING, '0,
                             cur.tok_line, cur.tok_col, '0, '0, 1'b0);
            n = n + 1'b1;
         end
         recs[n] = mk_rec(stt_pkg::KIND_TOKEN, stt_pkg::TOK_EOF, '0,
                          nxt.line, nxt.col, '0, '0, 1'b0);
         n = n + 1'b1;
         nxt.mode     = stt_pkg::MODE_IDLE;
         nxt.line     = first_line;
         nxt.col      = first_column;
         nxt.tok_line = '0;
         nxt.tok_col  = '0;
         nxt_len      = '0;
      end

      rec_count = n;
   end

endmodule
